[design/pvei_pkg.sv]
// Shared types and codes for the path verb edge iterator.
`default_nettype none
package pvei_pkg;

   // Path verb codes; codes above end of path are ignored.
   typedef enum logic [2:0] {
      ACT_MOVE  = 3'd0,
      ACT_LINE  = 3'd1,
      ACT_QUAD  = 3'd2,
      ACT_CUBIC = 3'd3,
      ACT_CLOSE = 3'd4,
      ACT_END   = 3'd5
   } action_type;

   // Emitted edge kinds.
   typedef enum logic [1:0] {
      EDGE_LINE  = 2'd0,
      EDGE_QUAD  = 2'd1,
      EDGE_CUBIC = 2'd2
   } edge_kind_type;

   localparam int unsigned CoordWidth = 32;

   typedef logic [CoordWidth-1:0] coord_type;

   typedef struct packed {
      logic [2:0] action;
      coord_type  pt1_x;
      coord_type  pt1_y;
      coord_type  pt2_x;
      coord_type  pt2_y;
      coord_type  pt3_x;
      coord_type  pt3_y;
   } req_payload_type;

   typedef struct packed {
      logic [1:0] edge_kind;
      coord_type  e0_x;
      coord_type  e0_y;
      coord_type  e1_x;
      coord_type  e1_y;
      coord_type  e2_x;
      coord_type  e2_y;
      coord_type  e3_x;
      coord_type  e3_y;
   } rsp_payload_type;

endpackage
`default_nettype wire

[design/pvei_in_stage.sv]
// Input register stage that holds one request for the edge generator.
`default_nettype none
module pvei_in_stage (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_ready,
   input  pvei_pkg::req_payload_type req_payload,
   output logic                     stage_valid,
   input  wire                      stage_take,
   output pvei_pkg::req_payload_type stage_payload
);
   import pvei_pkg::*;

   logic            valid_ff, valid_in;
   req_payload_type data_ff, data_in;

   // Accept when empty or when the held request leaves this cycle.
   assign req_ready = !valid_ff || stage_take;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (req_ready) begin
         valid_in = req_valid;
         data_in  = req_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign stage_valid   = valid_ff;
   assign stage_payload = data_ff;
endmodule
`default_nettype wire

[design/pvei_core.sv]
// Path state and edge generation, with the result register.
`default_nettype none
module pvei_core (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       stage_valid,
   output logic                      stage_take,
   input  pvei_pkg::req_payload_type stage_payload,
   output logic                      rsp_valid,
   input  wire                       rsp_ready,
   output pvei_pkg::rsp_payload_type rsp_payload
);
   import pvei_pkg::*;

   coord_type       start_x_ff, start_y_ff, prev_x_ff, prev_y_ff;
   coord_type       start_x_in, start_y_in, prev_x_in, prev_y_in;
   logic            close_pending_ff, close_pending_in;
   logic            have_point_ff, have_point_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;
   logic            emit;
   logic            close_due;
   rsp_payload_type edge_data;

   // Take the request whenever the result slot is free or draining.
   assign stage_take = stage_valid && (!rsp_valid_ff || rsp_ready);
   assign close_due  = close_pending_ff && have_point_ff;

   // Decode the verb into an edge and the next path state.
   always_comb begin
      start_x_in       = start_x_ff;
      start_y_in       = start_y_ff;
      prev_x_in        = prev_x_ff;
      prev_y_in        = prev_y_ff;
      close_pending_in = close_pending_ff;
      have_point_in    = have_point_ff;
      emit             = 1'b0;
      edge_data        = '0;
      edge_data.e0_x   = prev_x_ff;
      edge_data.e0_y   = prev_y_ff;
      edge_data.edge_kind = EDGE_LINE;
      edge_data.e1_x   = start_x_ff;
      edge_data.e1_y   = start_y_ff;
      unique case (stage_payload.action)
         ACT_MOVE: begin
            emit             = close_due;
            start_x_in       = stage_payload.pt1_x;
            start_y_in       = stage_payload.pt1_y;
            prev_x_in        = stage_payload.pt1_x;
            prev_y_in        = stage_payload.pt1_y;
            have_point_in    = 1'b1;
            close_pending_in = 1'b0;
         end
         ACT_LINE: begin
            emit           = have_point_ff;
            edge_data.e1_x = stage_payload.pt1_x;
            edge_data.e1_y = stage_payload.pt1_y;
            if (have_point_ff) begin
               prev_x_in        = stage_payload.pt1_x;
               prev_y_in        = stage_payload.pt1_y;
               close_pending_in = 1'b1;
            end
         end
         ACT_QUAD: begin
            emit                = have_point_ff;
            edge_data.edge_kind = EDGE_QUAD;
            edge_data.e1_x      = stage_payload.pt1_x;
            edge_data.e1_y      = stage_payload.pt1_y;
            edge_data.e2_x      = stage_payload.pt2_x;
            edge_data.e2_y      = stage_payload.pt2_y;
            if (have_point_ff) begin
               prev_x_in        = stage_payload.pt2_x;
               prev_y_in        = stage_payload.pt2_y;
               close_pending_in = 1'b1;
            end
         end
         ACT_CUBIC: begin
            emit                = have_point_ff;
            edge_data.edge_kind = EDGE_CUBIC;
            edge_data.e1_x      = stage_payload.pt1_x;
            edge_data.e1_y      = stage_payload.pt1_y;
            edge_data.e2_x      = stage_payload.pt2_x;
            edge_data.e2_y      = stage_payload.pt2_y;
            edge_data.e3_x      = stage_payload.pt3_x;
            edge_data.e3_y      = stage_payload.pt3_y;
            if (have_point_ff) begin
               prev_x_in        = stage_payload.pt3_x;
               prev_y_in        = stage_payload.pt3_y;
               close_pending_in = 1'b1;
            end
         end
         ACT_CLOSE: begin
            emit             = close_due;
            close_pending_in = 1'b0;
         end
         ACT_END: begin
            emit             = close_due;
            start_x_in       = '0;
            start_y_in       = '0;
            prev_x_in        = '0;
            prev_y_in        = '0;
            close_pending_in = 1'b0;
            have_point_in    = 1'b0;
         end
         default: begin
            // Drop unused codes without touching state.
            emit = 1'b0;
         end
      endcase
   end

   // Load the result register on a taken request; drain on handshake.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (stage_take) begin
         rsp_valid_in = emit;
         rsp_data_in  = edge_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff       <= '0;
         start_y_ff       <= '0;
         prev_x_ff        <= '0;
         prev_y_ff        <= '0;
         close_pending_ff <= 1'b0;
         have_point_ff    <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (stage_take) begin
            start_x_ff       <= start_x_in;
            start_y_ff       <= start_y_in;
            prev_x_ff        <= prev_x_in;
            prev_y_ff        <= prev_y_in;
            close_pending_ff <= close_pending_in;
            have_point_ff    <= have_point_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;
endmodule
`default_nettype wire

[design/path_verb_edge_iterator.sv]
// Path verb edge iterator top level: input stage, edge generator, assertions.
//
// Turns a stream of path verbs (move, line, quad, cubic, close, end of path) into
// line, quadratic and cubic edges, at most one edge per verb, each starting at the
// last point; move, close and end of path emit the closing line when one is due.
// The block takes one request per clock cycle unless the result side stalls: a
// request is held in an input register, decoded by plain multiplexing against
// the subpath start and last point, and its edge is loaded into the result
// register as the request leaves the input register. A move or end of path with no
// closing line due still updates the path state; a drawing verb before any point
// and the unused codes are dropped without touching it. A stall on the result side
// holds the input register, so up to two requests are in flight.
`default_nettype none
module path_verb_edge_iterator (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_ready,
   input  pvei_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  wire                       rsp_ready,
   output pvei_pkg::rsp_payload_type rsp_payload
);
   import pvei_pkg::*;

   logic            stage_valid;
   logic            stage_take;
   req_payload_type stage_payload;

   pvei_in_stage u_in_stage (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_payload   (req_payload),
      .stage_valid   (stage_valid),
      .stage_take    (stage_take),
      .stage_payload (stage_payload)
   );

   pvei_core u_core (
      .clock         (clock),
      .reset         (reset),
      .stage_valid   (stage_valid),
      .stage_take    (stage_take),
      .stage_payload (stage_payload),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_payload   (rsp_payload)
   );

   // An empty input stage always takes a new request.
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !stage_valid |-> req_ready)
      else $error("input stage empty but not ready");

   // A line edge carries no third or fourth point.
   a_line_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.edge_kind == EDGE_LINE) |->
      (rsp_payload.e2_x == '0 && rsp_payload.e2_y == '0 &&
       rsp_payload.e3_x == '0 && rsp_payload.e3_y == '0))
      else $error("line edge with nonzero upper points");

   // A quadratic edge carries no fourth point.
   a_quad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.edge_kind == EDGE_QUAD) |->
      (rsp_payload.e3_x == '0 && rsp_payload.e3_y == '0))
      else $error("quadratic edge with nonzero fourth point");

   // A result appears only after a request left the input stage.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(stage_take))
      else $error("result without a taken request");
endmodule
`default_nettype wire

[tb/path_edge_checker.sv]
// Edge checker: predicts edges from accepted path verb requests and compares results.
module path_edge_checker
   import pvei_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_ready,
   input  req_payload_type req_payload,
   input  logic            rsp_valid,
   input  logic            rsp_ready,
   input  rsp_payload_type rsp_payload,
   output int              mismatch_count,
   output int              edges_pending
);

   // Path state as the block should hold it
   coord_type sub_start_x, sub_start_y;
   coord_type pen_x, pen_y;
   bit        close_due;
   bit        pen_down;

   rsp_payload_type expected_edges[$];

   initial begin
      mismatch_count = 0;
      edges_pending  = 0;
   end

   // Clear the path state back to its reset values
   function automatic void clear_path();
      sub_start_x = '0;
      sub_start_y = '0;
      pen_x       = '0;
      pen_y       = '0;
      close_due   = 1'b0;
      pen_down    = 1'b0;
   endfunction

   // Build the closing line when one is due; drop the pending close either way
   function automatic bit closing_line(output rsp_payload_type seg);
      bit fire;
      seg  = '0;
      fire = close_due && pen_down;
      if (fire) begin
         seg.edge_kind = EDGE_LINE;
         seg.e0_x      = pen_x;
         seg.e0_y      = pen_y;
         seg.e1_x      = sub_start_x;
         seg.e1_y      = sub_start_y;
      end
      close_due = 1'b0;
      return fire;
   endfunction

   // Work out the edge a verb produces and advance the path state
   function automatic bit predict_edge(input req_payload_type verb, output rsp_payload_type seg);
      bit fire;
      seg  = '0;
      fire = 1'b0;
      case (verb.action)
         ACT_MOVE: begin
            fire        = closing_line(seg);
            sub_start_x = verb.pt1_x;
            sub_start_y = verb.pt1_y;
            pen_x       = verb.pt1_x;
            pen_y       = verb.pt1_y;
            pen_down    = 1'b1;
         end
         ACT_LINE, ACT_QUAD, ACT_CUBIC: begin
            // drawing with no last point is dropped
            if (pen_down) begin
               fire     = 1'b1;
               seg.e0_x = pen_x;
               seg.e0_y = pen_y;
               seg.e1_x = verb.pt1_x;
               seg.e1_y = verb.pt1_y;
               if (verb.action == ACT_LINE) begin
                  seg.edge_kind = EDGE_LINE;
                  pen_x         = verb.pt1_x;
                  pen_y         = verb.pt1_y;
               end else if (verb.action == ACT_QUAD) begin
                  seg.edge_kind = EDGE_QUAD;
                  seg.e2_x      = verb.pt2_x;
                  seg.e2_y      = verb.pt2_y;
                  pen_x         = verb.pt2_x;
                  pen_y         = verb.pt2_y;
               end else begin
                  seg.edge_kind = EDGE_CUBIC;
                  seg.e2_x      = verb.pt2_x;
                  seg.e2_y      = verb.pt2_y;
                  seg.e3_x      = verb.pt3_x;
                  seg.e3_y      = verb.pt3_y;
                  pen_x         = verb.pt3_x;
                  pen_y         = verb.pt3_y;
               end
               close_due = 1'b1;
            end
         end
         ACT_CLOSE: begin
            fire = closing_line(seg);
         end
         ACT_END: begin
            fire = closing_line(seg);
            clear_path();
         end
         default: begin
            fire = 1'b0;
         end
      endcase
      return fire;
   endfunction

   // Compare one field and count a mismatch
   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %h, actual %h", field, want, got);
         mismatch_count++;
      end
   endtask

   // Watch both channels at each clock edge
   always @(posedge clock) begin : watch
      rsp_payload_type seg;
      rsp_payload_type want;
      if (reset) begin
         clear_path();
         expected_edges.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_edges.size() == 0) begin
               $error("edge_kind: expected no edge, actual %0d", rsp_payload.edge_kind);
               mismatch_count++;
            end else begin
               want = expected_edges.pop_front();
               check_field("edge_kind", 32'(want.edge_kind), 32'(rsp_payload.edge_kind));
               check_field("e0_x", want.e0_x, rsp_payload.e0_x);
               check_field("e0_y", want.e0_y, rsp_payload.e0_y);
               check_field("e1_x", want.e1_x, rsp_payload.e1_x);
               check_field("e1_y", want.e1_y, rsp_payload.e1_y);
               check_field("e2_x", want.e2_x, rsp_payload.e2_x);
               check_field("e2_y", want.e2_y, rsp_payload.e2_y);
               check_field("e3_x", want.e3_x, rsp_payload.e3_x);
               check_field("e3_y", want.e3_y, rsp_payload.e3_y);
            end
         end
         if (req_valid && req_ready) begin
            if (predict_edge(req_payload, seg)) begin
               expected_edges = {expected_edges, seg};
            end
         end
      end
      edges_pending <= expected_edges.size();
   end

endmodule

[tb/tb_top.sv]
// Testbench top: clock, reset, path verb stimulus, result-side stalls and verdict.
module tb_top;
   import pvei_pkg::*;

   localparam logic [2:0]  ACT_SPARE_LO  = 3'd6;
   localparam logic [2:0]  ACT_SPARE_HI  = 3'd7;
   localparam int unsigned IDLE_PERCENT  = 11;
   localparam int unsigned RANDOM_ITEMS  = 650;
   localparam int unsigned HOLD_CYCLES   = 60;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned CYCLE_LIMIT   = 200000;

   logic            clock       = 1'b0;
   logic            reset       = 1'b1;
   logic            req_valid   = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready   = 1'b0;
   rsp_payload_type rsp_payload;

   int          mismatch_count;
   int          edges_pending;
   int unsigned cycle_count = 0;

   // Quiet stretch: no idling on either side
   bit quiet       = 1'b0;
   bit hold_begun  = 1'b0;
   bit hold_over   = 1'b0;
   bit path_open   = 1'b0;
   int unsigned sent = 0;

   path_verb_edge_iterator DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   path_edge_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_payload    (rsp_payload),
      .mismatch_count (mismatch_count),
      .edges_pending  (edges_pending)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Result side: random stalls, plus one long hold-off on request
   initial begin : receiver
      forever begin
         @(posedge clock);
         if (hold_begun && !hold_over) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_over = 1'b1;
         end else begin
            rsp_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PERCENT);
         end
      end
   end

   // Pick a coordinate, favoring extremes and float-like patterns
   function automatic coord_type rand_coord();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return 32'h8000_0000;
         3:       return {1'($urandom_range(0, 1)), 8'($urandom_range(120, 135)),
                          23'($urandom())};
         default: return $urandom();
      endcase
   endfunction

   // Directed request: pt1 = (a, b), pt2 = (~a, ~b), pt3 = (b, a)
   function automatic req_payload_type fixed_request(input logic [2:0] code,
                                                     input coord_type a, input coord_type b);
      req_payload_type r;
      r.action = code;
      r.pt1_x  = a;
      r.pt1_y  = b;
      r.pt2_x  = ~a;
      r.pt2_y  = ~b;
      r.pt3_x  = b;
      r.pt3_y  = a;
      return r;
   endfunction

   // Offer one request, idling first at random; return once it is accepted
   task automatic issue_request(input req_payload_type r);
      if (!quiet && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
   endtask

   // Send a verb with random points and count it if the block acts on it
   task automatic offer(input logic [2:0] code);
      req_payload_type r;
      r.action = code;
      r.pt1_x  = rand_coord();
      r.pt1_y  = rand_coord();
      r.pt2_x  = rand_coord();
      r.pt2_y  = rand_coord();
      r.pt3_x  = rand_coord();
      r.pt3_y  = rand_coord();
      issue_request(r);
      if (code == ACT_MOVE || code == ACT_CLOSE || code == ACT_END) begin
         sent++;
      end else if (code <= ACT_CUBIC && path_open) begin
         sent++;
      end
      if (code == ACT_MOVE) path_open = 1'b1;
      if (code == ACT_END) path_open = 1'b0;
   endtask

   // Drop valid and wait until every expected edge has come back
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (edges_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic draw_verbs(input int unsigned count);
      repeat (count) offer(3'($urandom_range(ACT_LINE, ACT_CUBIC)));
   endtask

   initial begin : stimulus
      int unsigned pick;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Drawing, close and end before any point, then unused codes
      issue_request(fixed_request(ACT_LINE, 32'h1, 32'h2));
      issue_request(fixed_request(ACT_QUAD, '1, '0));
      issue_request(fixed_request(ACT_CUBIC, '0, '1));
      issue_request(fixed_request(ACT_CLOSE, '1, '1));
      issue_request(fixed_request(ACT_END, '0, '0));
      issue_request(fixed_request(ACT_SPARE_LO, '1, '0));
      issue_request(fixed_request(ACT_SPARE_HI, '0, '1));

      // Full subpath with extreme coordinates, double close, line after close
      issue_request(fixed_request(ACT_MOVE, '1, '0));
      issue_request(fixed_request(ACT_LINE, '0, '1));
      issue_request(fixed_request(ACT_QUAD, 32'h8000_0000, 32'h7FFF_FFFF));
      issue_request(fixed_request(ACT_CUBIC, '1, '1));
      issue_request(fixed_request(ACT_CLOSE, 32'h1234_5678, 32'h9ABC_DEF0));
      issue_request(fixed_request(ACT_CLOSE, '0, '0));
      issue_request(fixed_request(ACT_LINE, 32'h3F80_0000, 32'h4000_0000));
      issue_request(fixed_request(ACT_SPARE_HI, '1, '1));

      // Move with a pending close, end with a pending close, draw after end
      issue_request(fixed_request(ACT_MOVE, '0, '0));
      issue_request(fixed_request(ACT_CUBIC, 32'hC000_0000, 32'h0000_0001));
      issue_request(fixed_request(ACT_END, '1, '1));
      issue_request(fixed_request(ACT_LINE, 32'h5555_5555, 32'hAAAA_AAAA));
      issue_request(fixed_request(ACT_MOVE, 32'h1, 32'h1));
      issue_request(fixed_request(ACT_QUAD, 32'hAAAA_AAAA, 32'h5555_5555));
      issue_request(fixed_request(ACT_MOVE, 32'h2, 32'h2));
      issue_request(fixed_request(ACT_END, '0, '0));
      drain();

      // Random subpaths with some noise mixed in
      while (sent < RANDOM_ITEMS) begin
         if (sent >= 100 && !hold_begun) hold_begun = 1'b1;
         quiet = (sent >= 250 && sent < 350);
         if (sent >= 450 && sent < 470) begin
            drain();
            sent = 470;
         end
         if ($urandom_range(0, 99) < 12) begin
            offer(3'($urandom_range(0, 7)));
         end else begin
            offer(ACT_MOVE);
            draw_verbs($urandom_range(1, 6));
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
               offer(ACT_CLOSE);
               if ($urandom_range(0, 99) < 30) draw_verbs($urandom_range(1, 2));
            end else if (pick < 75) begin
               offer(ACT_END);
            end
         end
      end

      drain();
      if (mismatch_count == 0 && edges_pending == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
